// File: rtl/qrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_pkg
// Widths, constants and helpers for the quaternion rotate and translate unit.
// ----------------------------------------------------------------------------
package qrt_pkg;

    // port width of every position and quaternion field
    localparam int IO_W   = 32;
    // bits of a position field that carry the signed Q16.16 value
    localparam int POS_W  = 32;
    // quaternion component width, Q2.30
    localparam int Q_W    = 32;
    localparam int Q_FRAC = 30;

    // doubled product 2*a*b floored to Q_FRAC fraction bits
    localparam int P_W    = 2 * Q_W;
    localparam int DBL_SH = Q_FRAC - 1;
    localparam int D_W    = P_W - DBL_SH;
    // matrix entry: one minus two doubled products on the diagonal, else the sum or difference of two
    localparam int M_W    = D_W + 1;

    // the point is split into a high part and an unsigned low part of SPLIT bits
    localparam int SPLIT  = 24;
    localparam int VX_W   = (POS_W > SPLIT) ? POS_W : SPLIT + 1;
    localparam int VH_W   = VX_W - SPLIT;
    localparam int VL_W   = SPLIT + 1;
    localparam int PH_W   = VH_W + M_W;
    localparam int PL_W   = VL_W + M_W;

    // shift that takes the high sum from 22 to 16 fraction bits
    localparam int RND_SH = Q_FRAC - SPLIT;
    localparam int HI_W   = ((PH_W > POS_W + RND_SH) ? PH_W : POS_W + RND_SH) + 2;
    localparam int LO_W   = PL_W + 2;
    localparam int LOS_W  = LO_W - SPLIT;
    localparam int TOT_W  = ((HI_W > LOS_W) ? HI_W : LOS_W) + 1;
    localparam int SUM_W  = TOT_W - RND_SH;

    localparam logic signed [M_W-1:0]  Q_ONE    = M_W'(64'd1 << Q_FRAC);
    localparam logic signed [LO_W-1:0] HALF_LSB = LO_W'(64'd1 << (Q_FRAC - 1));

    localparam logic [POS_W-1:0] SAT_MAX = {1'b0, {(POS_W - 1){1'b1}}};
    localparam logic [POS_W-1:0] SAT_MIN = {1'b1, {(POS_W - 1){1'b0}}};

    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } t_mat_ctl;

    typedef struct packed {
        logic s3_en;
        logic s4_en;
        logic s5_en;
    } t_rot_ctl;

    // 2*a*b with Q_FRAC fraction bits, floored
    function automatic logic signed [D_W-1:0] dbl(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
        logic signed [P_W-1:0] p;
        p = a * b;
        return p[P_W-1:DBL_SH];
    endfunction

endpackage

// File: rtl/quaternion_rotate_translate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_translate_unit
// Takes each point from the camera frame into the global frame: rotation by
// the camera quaternion, then translation by the camera position, saturated.
// ----------------------------------------------------------------------------
// The unit is a five-stage pipeline that takes one item per clock while
// o_stall is low and presents each result from the fifth stage register.
// The depth comes from the multiplier stages: quaternion products, matrix
// entries, split matrix-times-point products, row sums, and the final
// rounding with saturation. Each stage holds its item when the next one is
// full, so bubbles close up and o_stall rises only once all five stages hold
// items and the output is stalled. Quaternions are used as given, so a
// non-unit quaternion also scales the point; o_overflow marks any clipped
// component.
module quaternion_rotate_translate_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_local_x,
    input  logic [31:0] i_local_y,
    input  logic [31:0] i_local_z,
    input  logic [31:0] i_cam_x,
    input  logic [31:0] i_cam_y,
    input  logic [31:0] i_cam_z,
    input  logic [31:0] i_quat_w,
    input  logic [31:0] i_quat_x,
    input  logic [31:0] i_quat_y,
    input  logic [31:0] i_quat_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_global_x,
    output logic [31:0] o_global_y,
    output logic [31:0] o_global_z,
    output logic        o_overflow
);

    logic [5:1]                       r_vld;
    logic [5:1]                       n_vld;
    logic [5:1]                       en;
    qrt_pkg::t_mat_ctl                mat_ctl;
    qrt_pkg::t_rot_ctl                rot_ctl;

    logic signed [qrt_pkg::POS_W-1:0] pl_x, pl_y, pl_z;
    logic signed [qrt_pkg::VX_W-1:0]  v_in [3];
    logic signed [qrt_pkg::POS_W-1:0] c_in [3];
    logic signed [qrt_pkg::M_W-1:0]   m_mid [3][3];
    logic signed [qrt_pkg::VX_W-1:0]  v_mid [3];
    logic signed [qrt_pkg::POS_W-1:0] c_mid [3];
    logic        [qrt_pkg::POS_W-1:0] pos_out [3];
    logic                             ovf_out;

    // a stage loads when it is empty or its item moves on
    always_comb begin
        en[5] = !r_vld[5] || !i_stall;
        for (int s = 4; s >= 1; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
        n_vld = r_vld;
        for (int s = 5; s >= 2; s--) begin
            if (en[s]) begin
                n_vld[s] = r_vld[s-1];
            end
        end
        if (en[1]) begin
            n_vld[1] = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign mat_ctl.s1_en = en[1];
    assign mat_ctl.s2_en = en[2];
    assign rot_ctl.s3_en = en[3];
    assign rot_ctl.s4_en = en[4];
    assign rot_ctl.s5_en = en[5];

    // the low POS_W bits of each position port carry the value
    assign pl_x = i_local_x[qrt_pkg::POS_W-1:0];
    assign pl_y = i_local_y[qrt_pkg::POS_W-1:0];
    assign pl_z = i_local_z[qrt_pkg::POS_W-1:0];
    assign v_in[0] = qrt_pkg::VX_W'(pl_x);
    assign v_in[1] = qrt_pkg::VX_W'(pl_y);
    assign v_in[2] = qrt_pkg::VX_W'(pl_z);
    assign c_in[0] = i_cam_x[qrt_pkg::POS_W-1:0];
    assign c_in[1] = i_cam_y[qrt_pkg::POS_W-1:0];
    assign c_in[2] = i_cam_z[qrt_pkg::POS_W-1:0];

    qrt_matrix u_matrix (
        .i_clk (i_clk),
        .i_ctl (mat_ctl),
        .i_qw  (i_quat_w),
        .i_qx  (i_quat_x),
        .i_qy  (i_quat_y),
        .i_qz  (i_quat_z),
        .i_v   (v_in),
        .i_c   (c_in),
        .o_m   (m_mid),
        .o_v   (v_mid),
        .o_c   (c_mid)
    );

    qrt_rotate u_rotate (
        .i_clk (i_clk),
        .i_ctl (rot_ctl),
        .i_m   (m_mid),
        .i_v   (v_mid),
        .i_c   (c_mid),
        .o_pos (pos_out),
        .o_ovf (ovf_out)
    );

    assign o_stall    = !en[1];
    assign o_valid    = r_vld[5];
    assign o_global_x = qrt_pkg::IO_W'(pos_out[0]);
    assign o_global_y = qrt_pkg::IO_W'(pos_out[1]);
    assign o_global_z = qrt_pkg::IO_W'(pos_out[2]);
    assign o_overflow = ovf_out;

    // input is held back only when every stage holds an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld && i_stall))
        else $error("input stalled while pipeline has room");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[1])
        else $error("accepted item lost at pipeline entry");

    // overflow only with a component clipped to a rail
    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (pos_out[0] == qrt_pkg::SAT_MAX || pos_out[0] == qrt_pkg::SAT_MIN ||
             pos_out[1] == qrt_pkg::SAT_MAX || pos_out[1] == qrt_pkg::SAT_MIN ||
             pos_out[2] == qrt_pkg::SAT_MAX || pos_out[2] == qrt_pkg::SAT_MIN))
        else $error("overflow flagged without a saturated component");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("valid bits survive reset");

endmodule

// File: rtl/qrt_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_matrix
// Stages one and two: doubled quaternion products, then the rotation matrix.
// The point and camera position ride along with the matrix.
// ----------------------------------------------------------------------------
module qrt_matrix (
    input  logic                                i_clk,
    input  qrt_pkg::t_mat_ctl                   i_ctl,
    input  logic signed [qrt_pkg::Q_W-1:0]      i_qw,
    input  logic signed [qrt_pkg::Q_W-1:0]      i_qx,
    input  logic signed [qrt_pkg::Q_W-1:0]      i_qy,
    input  logic signed [qrt_pkg::Q_W-1:0]      i_qz,
    input  logic signed [qrt_pkg::VX_W-1:0]     i_v [3],
    input  logic signed [qrt_pkg::POS_W-1:0]    i_c [3],
    output logic signed [qrt_pkg::M_W-1:0]      o_m [3][3],
    output logic signed [qrt_pkg::VX_W-1:0]     o_v [3],
    output logic signed [qrt_pkg::POS_W-1:0]    o_c [3]
);

    logic signed [qrt_pkg::D_W-1:0]   r_wx, r_wy, r_wz;
    logic signed [qrt_pkg::D_W-1:0]   r_xx, r_xy, r_xz;
    logic signed [qrt_pkg::D_W-1:0]   r_yy, r_yz, r_zz;
    logic signed [qrt_pkg::VX_W-1:0]  r_v1 [3];
    logic signed [qrt_pkg::POS_W-1:0] r_c1 [3];

    logic signed [qrt_pkg::M_W-1:0]   r_m  [3][3];
    logic signed [qrt_pkg::M_W-1:0]   n_m  [3][3];
    logic signed [qrt_pkg::VX_W-1:0]  r_v2 [3];
    logic signed [qrt_pkg::POS_W-1:0] r_c2 [3];

    // stage one: nine multipliers
    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_en) begin
            r_wx <= qrt_pkg::dbl(i_qw, i_qx);
            r_wy <= qrt_pkg::dbl(i_qw, i_qy);
            r_wz <= qrt_pkg::dbl(i_qw, i_qz);
            r_xx <= qrt_pkg::dbl(i_qx, i_qx);
            r_xy <= qrt_pkg::dbl(i_qx, i_qy);
            r_xz <= qrt_pkg::dbl(i_qx, i_qz);
            r_yy <= qrt_pkg::dbl(i_qy, i_qy);
            r_yz <= qrt_pkg::dbl(i_qy, i_qz);
            r_zz <= qrt_pkg::dbl(i_qz, i_qz);
            r_v1 <= i_v;
            r_c1 <= i_c;
        end
    end

    always_comb begin
        n_m[0][0] = qrt_pkg::Q_ONE - qrt_pkg::M_W'(r_yy) - qrt_pkg::M_W'(r_zz);
        n_m[0][1] = qrt_pkg::M_W'(r_xy) - qrt_pkg::M_W'(r_wz);
        n_m[0][2] = qrt_pkg::M_W'(r_xz) + qrt_pkg::M_W'(r_wy);
        n_m[1][0] = qrt_pkg::M_W'(r_xy) + qrt_pkg::M_W'(r_wz);
        n_m[1][1] = qrt_pkg::Q_ONE - qrt_pkg::M_W'(r_xx) - qrt_pkg::M_W'(r_zz);
        n_m[1][2] = qrt_pkg::M_W'(r_yz) - qrt_pkg::M_W'(r_wx);
        n_m[2][0] = qrt_pkg::M_W'(r_xz) - qrt_pkg::M_W'(r_wy);
        n_m[2][1] = qrt_pkg::M_W'(r_yz) + qrt_pkg::M_W'(r_wx);
        n_m[2][2] = qrt_pkg::Q_ONE - qrt_pkg::M_W'(r_xx) - qrt_pkg::M_W'(r_yy);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_en) begin
            r_m  <= n_m;
            r_v2 <= r_v1;
            r_c2 <= r_c1;
        end
    end

    assign o_m = r_m;
    assign o_v = r_v2;
    assign o_c = r_c2;

endmodule

// File: rtl/qrt_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrt_rotate
// Stages three to five: matrix times point in split partial products, row
// sums with rounding and translation, then saturation to the position width.
// ----------------------------------------------------------------------------
module qrt_rotate (
    input  logic                                i_clk,
    input  qrt_pkg::t_rot_ctl                   i_ctl,
    input  logic signed [qrt_pkg::M_W-1:0]      i_m [3][3],
    input  logic signed [qrt_pkg::VX_W-1:0]     i_v [3],
    input  logic signed [qrt_pkg::POS_W-1:0]    i_c [3],
    output logic        [qrt_pkg::POS_W-1:0]    o_pos [3],
    output logic                                o_ovf
);

    logic signed [qrt_pkg::PH_W-1:0]  r_ph [3][3];
    logic signed [qrt_pkg::PL_W-1:0]  r_pl [3][3];
    logic signed [qrt_pkg::PH_W-1:0]  n_ph [3][3];
    logic signed [qrt_pkg::PL_W-1:0]  n_pl [3][3];
    logic signed [qrt_pkg::POS_W-1:0] r_c3 [3];

    logic signed [qrt_pkg::HI_W-1:0]  r_hi [3];
    logic signed [qrt_pkg::LO_W-1:0]  r_lo [3];
    logic signed [qrt_pkg::HI_W-1:0]  n_hi [3];
    logic signed [qrt_pkg::LO_W-1:0]  n_lo [3];

    logic        [qrt_pkg::POS_W-1:0] r_pos [3];
    logic        [qrt_pkg::POS_W-1:0] n_pos [3];
    logic                             r_ovf;
    logic                             n_ovf;

    logic signed [qrt_pkg::VH_W-1:0]  vh [3];
    logic signed [qrt_pkg::VL_W-1:0]  vl [3];

    // point split so every product stays near one multiplier in width
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vh[k] = i_v[k][qrt_pkg::VX_W-1:qrt_pkg::SPLIT];
            vl[k] = {1'b0, i_v[k][qrt_pkg::SPLIT-1:0]};
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_ph[r][k] = vh[k] * i_m[r][k];
                n_pl[r][k] = vl[k] * i_m[r][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_en) begin
            r_ph <= n_ph;
            r_pl <= n_pl;
            r_c3 <= i_c;
        end
    end

    // camera position folded into the high sum ahead of the final shift
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_hi[r] = qrt_pkg::HI_W'(r_c3[r]) <<< qrt_pkg::RND_SH;
            n_lo[r] = qrt_pkg::HALF_LSB;
            for (int k = 0; k < 3; k++) begin
                n_hi[r] = n_hi[r] + qrt_pkg::HI_W'(r_ph[r][k]);
                n_lo[r] = n_lo[r] + qrt_pkg::LO_W'(r_pl[r][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s4_en) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    always_comb begin
        logic signed [qrt_pkg::TOT_W-1:0]         tot;
        logic signed [qrt_pkg::SUM_W-1:0]         sum;
        logic        [qrt_pkg::SUM_W-qrt_pkg::POS_W:0] upper;
        n_ovf = 1'b0;
        for (int r = 0; r < 3; r++) begin
            tot   = qrt_pkg::TOT_W'(r_hi[r])
                  + qrt_pkg::TOT_W'($signed(r_lo[r][qrt_pkg::LO_W-1:qrt_pkg::SPLIT]));
            sum   = tot[qrt_pkg::TOT_W-1:qrt_pkg::RND_SH];
            upper = sum[qrt_pkg::SUM_W-1:qrt_pkg::POS_W-1];
            if (&upper || ~|upper) begin
                n_pos[r] = sum[qrt_pkg::POS_W-1:0];
            end else begin
                n_ovf    = 1'b1;
                n_pos[r] = sum[qrt_pkg::SUM_W-1] ? qrt_pkg::SAT_MIN : qrt_pkg::SAT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s5_en) begin
            r_pos <= n_pos;
            r_ovf <= n_ovf;
        end
    end

    assign o_pos = r_pos;
    assign o_ovf = r_ovf;

endmodule
